/* rtl/efcc_pkg.sv */
package efcc_pkg;

    localparam int CRC_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int FRAME_LEN_W = 9;

    typedef logic [CRC_W-1:0]       t_crc;
    typedef logic [BYTE_W-1:0]      t_byte;
    typedef logic [1:0]             t_status;
    typedef logic [2:0]             t_kind;
    typedef logic [FRAME_LEN_W-1:0] t_frame_len;

    localparam t_crc CRC_INIT   = 16'hFFFF;
    localparam t_crc POLY_RESET = 16'hA001;

    // Configuration register indexes.
    localparam logic CFG_POLYNOMIAL  = 1'b0;
    localparam logic CFG_PREFIX_MODE = 1'b1;

    localparam t_status STATUS_GOOD      = 2'd0;
    localparam t_status STATUS_CRC_ERR   = 2'd1;
    localparam t_status STATUS_TOO_SHORT = 2'd2;
    localparam t_status STATUS_TOO_LONG  = 2'd3;

    localparam t_kind KIND_OTHER       = 3'd0;
    localparam t_kind KIND_CONNECT_ACK = 3'd1;
    localparam t_kind KIND_PROFILE_REQ = 3'd2;
    localparam t_kind KIND_TELEMETRY   = 3'd3;
    localparam t_kind KIND_PARAM_REQ   = 3'd4;

    localparam t_byte HDR_SYNC       = 8'hFE;
    localparam t_byte HDR_TYPE       = 8'h03;
    localparam t_byte HDR_CMD_CONN   = 8'h2C;
    localparam t_byte HDR_SUB_ACK    = 8'h24;
    localparam t_byte HDR_SUB_PROF   = 8'h25;
    localparam t_byte HDR_CMD_TELEM  = 8'h30;
    localparam t_byte HDR_SUB_TELEM  = 8'h5C;
    localparam t_byte HDR_CMD_PARAM  = 8'h31;
    localparam t_byte HDR_SUB_PARAM  = 8'h38;

    // The transmit prefix is three bytes long; the step counter stops here.
    localparam logic [1:0] PREFIX_DONE = 2'd3;

    typedef struct packed {
        logic busy;
        t_crc seed;
    } t_seed_info;

    function automatic t_byte prefix_byte(input logic [1:0] idx);
        t_byte b;
        unique case (idx)
            2'd0:    b = 8'h01;
            2'd1:    b = 8'hFE;
            2'd2:    b = 8'h04;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // One byte of a reflected CRC, eight shift steps.
    function automatic t_crc crc_byte(input t_crc crc_in, input t_byte b, input t_crc poly);
        t_crc c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/efcc_if.sv */
interface efcc_in_if;
    logic                 valid;
    logic                 ready;
    efcc_pkg::t_byte      data_byte;
    logic                 last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface efcc_out_if;
    logic                 valid;
    logic                 ready;
    efcc_pkg::t_status    status;
    efcc_pkg::t_kind      frame_kind;
    efcc_pkg::t_crc       computed_crc;
    efcc_pkg::t_frame_len frame_length;

    modport source (output valid, output status, output frame_kind, output computed_crc,
                    output frame_length, input ready);
    modport sink   (input valid, input status, input frame_kind, input computed_crc,
                    input frame_length, output ready);
endinterface

/* rtl/efcc_seed_gen.sv */
module efcc_seed_gen (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  efcc_pkg::t_crc       i_poly,
    input  logic                 i_restart,
    output efcc_pkg::t_seed_info o_seed
);

    logic [1:0]     r_step;
    efcc_pkg::t_crc r_seed;

    // Runs the three prefix bytes through the CRC, one byte per cycle, whenever
    // the polynomial changes, so that a frame start only has to pick the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_step <= '0;
            r_seed <= efcc_pkg::CRC_INIT;
        end else if (r_step != efcc_pkg::PREFIX_DONE) begin
            r_step <= r_step + 2'd1;
            r_seed <= efcc_pkg::crc_byte(r_seed, efcc_pkg::prefix_byte(r_step), i_poly);
        end
    end

    assign o_seed.busy = (r_step != efcc_pkg::PREFIX_DONE);
    assign o_seed.seed = r_seed;

endmodule

/* rtl/esc_frame_crc_checker.sv */
// Frame checker for ESC serial frames.
// Bytes enter on i_byte (valid/ready), one item per byte, with last_byte set on
// the final byte of a frame. One result item per frame leaves on o_result:
// status, frame kind, the CRC over all but the final two bytes, and the length.
// The final two bytes are the checksum, low byte first.
// Throughput is one byte per cycle while i_byte.ready is high; the byte-wide CRC
// update sits between the frame state registers and itself. The edge that accepts
// a frame's last byte loads the finished frame snapshot, and the output register,
// from which the result is offered, takes it over once it is free.
// Configuration: i_cfg_we/i_cfg_index/i_cfg_data write the polynomial (index 0)
// or the prefix mode (index 1). After reset and after every polynomial write,
// i_byte.ready stays low while the prefixed seed is rebuilt.
// Reset clears the frame state and the output valid and loads the default
// polynomial 0xA001 with the prefix off.
// When the receiver stalls, the output register holds and the next finished
// frame waits in the snapshot. While the snapshot is occupied and the output
// register cannot be emptied, i_byte.ready is low for every byte.
module esc_frame_crc_checker #(
    parameter int MAX_FRAME = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    efcc_in_if.sink           i_byte,
    efcc_out_if.source        o_result
);

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_FRAME);
    localparam logic [CW-1:0] COUNT_MIN = CW'(3);
    localparam int LW = efcc_pkg::FRAME_LEN_W;

    // Configuration
    efcc_pkg::t_crc       r_poly;
    logic                 r_prefix;
    efcc_pkg::t_seed_info seed_info;
    logic                 seed_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly   <= efcc_pkg::POLY_RESET;
            r_prefix <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                efcc_pkg::CFG_POLYNOMIAL:  r_poly   <= i_cfg_data;
                efcc_pkg::CFG_PREFIX_MODE: r_prefix <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign seed_restart = i_cfg_we && (i_cfg_index == efcc_pkg::CFG_POLYNOMIAL);

    efcc_seed_gen u_seed_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_poly    (r_poly),
        .i_restart (seed_restart),
        .o_seed    (seed_info)
    );

    // Handshake
    logic out_free, fin_move, fin_free, in_ready, accept, last_accept;

    logic r_out_valid;
    logic r_fin_valid;

    assign out_free    = !r_out_valid || o_result.ready;
    assign fin_move    = r_fin_valid && out_free;
    assign fin_free    = !r_fin_valid || out_free;
    assign in_ready    = !seed_info.busy && fin_free;
    assign accept      = i_byte.valid && in_ready;
    assign last_accept = accept && i_byte.last_byte;
    assign i_byte.ready = in_ready;

    // Frame state
    efcc_pkg::t_crc  r_crc, n_crc;
    logic [CW-1:0]   r_count, n_count;
    efcc_pkg::t_byte r_dly0, r_dly1, n_dly0, n_dly1;
    efcc_pkg::t_byte r_hdr0, r_hdr3, r_hdr4, r_hdr5;
    efcc_pkg::t_byte n_hdr0, n_hdr3, n_hdr4, n_hdr5;
    logic            r_ovf, n_ovf;
    efcc_pkg::t_crc  crc_base;

    always_comb begin
        crc_base = r_crc;
        if (r_count == '0 && !r_ovf) begin
            crc_base = r_prefix ? seed_info.seed : efcc_pkg::CRC_INIT;
        end
        // The byte two places back leaves the delay line into the CRC.
        n_crc = crc_base;
        if (r_count >= CW'(2) || r_ovf) begin
            n_crc = efcc_pkg::crc_byte(crc_base, r_dly0, r_poly);
        end
        n_dly0 = r_dly1;
        n_dly1 = i_byte.data_byte;

        n_hdr0 = r_hdr0;
        n_hdr3 = r_hdr3;
        n_hdr4 = r_hdr4;
        n_hdr5 = r_hdr5;
        if (!r_ovf) begin
            if (r_count == CW'(0)) n_hdr0 = i_byte.data_byte;
            if (r_count == CW'(3)) n_hdr3 = i_byte.data_byte;
            if (r_count == CW'(4)) n_hdr4 = i_byte.data_byte;
            if (r_count == CW'(5)) n_hdr5 = i_byte.data_byte;
        end

        n_ovf   = r_ovf;
        n_count = r_count;
        if (r_count == COUNT_MAX) begin
            n_ovf = 1'b1;
        end else begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || last_accept) begin
            r_crc   <= efcc_pkg::CRC_INIT;
            r_count <= '0;
            r_dly0  <= '0;
            r_dly1  <= '0;
            r_hdr0  <= '0;
            r_hdr3  <= '0;
            r_hdr4  <= '0;
            r_hdr5  <= '0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            r_crc   <= n_crc;
            r_count <= n_count;
            r_dly0  <= n_dly0;
            r_dly1  <= n_dly1;
            r_hdr0  <= n_hdr0;
            r_hdr3  <= n_hdr3;
            r_hdr4  <= n_hdr4;
            r_hdr5  <= n_hdr5;
            r_ovf   <= n_ovf;
        end
    end

    // Snapshot of a finished frame
    efcc_pkg::t_crc  r_fin_crc;
    efcc_pkg::t_crc  r_fin_chk;
    logic [CW-1:0]   r_fin_count;
    efcc_pkg::t_byte r_fin_hdr0, r_fin_hdr3, r_fin_hdr4, r_fin_hdr5;
    logic            r_fin_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (last_accept) begin
            r_fin_valid <= 1'b1;
        end else if (fin_move) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (last_accept) begin
            r_fin_crc   <= n_crc;
            r_fin_chk   <= {i_byte.data_byte, r_dly1};
            r_fin_count <= n_count;
            r_fin_hdr0  <= n_hdr0;
            r_fin_hdr3  <= n_hdr3;
            r_fin_hdr4  <= n_hdr4;
            r_fin_hdr5  <= n_hdr5;
            r_fin_ovf   <= n_ovf;
        end
    end

    // Status and frame kind
    efcc_pkg::t_status fin_status;
    efcc_pkg::t_kind   fin_kind;
    efcc_pkg::t_kind   hdr_kind;
    logic [CW+LW-1:0]  len_ext;

    always_comb begin
        hdr_kind = efcc_pkg::KIND_OTHER;
        if (r_fin_hdr0 == efcc_pkg::HDR_SYNC && r_fin_hdr3 == efcc_pkg::HDR_TYPE) begin
            if (r_fin_hdr4 == efcc_pkg::HDR_CMD_CONN && r_fin_hdr5 == efcc_pkg::HDR_SUB_ACK) begin
                hdr_kind = efcc_pkg::KIND_CONNECT_ACK;
            end else if (r_fin_hdr4 == efcc_pkg::HDR_CMD_CONN
                         && r_fin_hdr5 == efcc_pkg::HDR_SUB_PROF) begin
                hdr_kind = efcc_pkg::KIND_PROFILE_REQ;
            end else if (r_fin_hdr4 == efcc_pkg::HDR_CMD_TELEM
                         && r_fin_hdr5 == efcc_pkg::HDR_SUB_TELEM) begin
                hdr_kind = efcc_pkg::KIND_TELEMETRY;
            end else if (r_fin_hdr4 == efcc_pkg::HDR_CMD_PARAM
                         && r_fin_hdr5 == efcc_pkg::HDR_SUB_PARAM) begin
                hdr_kind = efcc_pkg::KIND_PARAM_REQ;
            end
        end

        fin_kind = efcc_pkg::KIND_OTHER;
        if (r_fin_ovf) begin
            fin_status = efcc_pkg::STATUS_TOO_LONG;
        end else if (r_fin_count < COUNT_MIN) begin
            fin_status = efcc_pkg::STATUS_TOO_SHORT;
        end else if (r_fin_chk != r_fin_crc) begin
            fin_status = efcc_pkg::STATUS_CRC_ERR;
        end else begin
            fin_status = efcc_pkg::STATUS_GOOD;
            fin_kind   = hdr_kind;
        end
    end

    assign len_ext = {{LW{1'b0}}, r_fin_count};

    // Output register
    efcc_pkg::t_status    r_out_status;
    efcc_pkg::t_kind      r_out_kind;
    efcc_pkg::t_crc       r_out_crc;
    efcc_pkg::t_frame_len r_out_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_move) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_move) begin
            r_out_status <= fin_status;
            r_out_kind   <= fin_kind;
            r_out_crc    <= r_fin_crc;
            r_out_len    <= len_ext[LW-1:0];
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out_status;
    assign o_result.frame_kind   = r_out_kind;
    assign o_result.computed_crc = r_out_crc;
    assign o_result.frame_length = r_out_len;

    // Checks
    a_no_input_while_seeding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seed_info.busy |-> !i_byte.ready)
        else $error("byte input open while the seed is being rebuilt");

    a_last_loads_snapshot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_accept |=> r_fin_valid && r_count == '0 && !r_ovf)
        else $error("frame end did not load the snapshot and clear the frame state");

    a_overflow_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == COUNT_MAX)
        else $error("overflow flag set below the maximum frame length");

    a_snapshot_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid && !out_free |=> r_fin_valid && $stable(r_fin_crc)
            && $stable(r_fin_count))
        else $error("stalled frame snapshot changed");

endmodule
